// ===== hw/rtl/fps_pkg.sv =====
package fps_pkg;

  // Default line buffer depth, in pixels.
  localparam int MAX_WIDTH_DEF = 1024;

  localparam int PIX_W = 16;
  localparam int RW_W  = 11;
  localparam int WT_W  = 16;
  localparam int ENT_W = PIX_W + 1;

  // Register reset values.
  localparam logic [RW_W-1:0] ROW_WIDTH_RST       = 11'd1024;
  localparam logic [WT_W-1:0] CENTER_WEIGHT_RST   = 16'd39322;
  localparam logic [WT_W-1:0] NEIGHBOR_WEIGHT_RST = 16'd6554;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_ROW_WIDTH       = 2'd0;
  localparam logic [1:0] REG_CENTER_WEIGHT   = 2'd1;
  localparam logic [1:0] REG_NEIGHBOR_WEIGHT = 2'd2;

  typedef struct packed {
    logic [RW_W-1:0] row_width;
    logic [WT_W-1:0] center_weight;
    logic [WT_W-1:0] neighbor_weight;
  } cfg_t;

  // Line buffer entries: bit 16 marks a tile pixel, bits 15..0 the value.
  typedef struct packed {
    logic [ENT_W-1:0] held;
    logic [ENT_W-1:0] up;
    logic [ENT_W-1:0] right;
  } win_t;

  typedef struct packed {
    logic left_en;
    logic right_en;
    logic up_en;
    logic rows_ok;
  } flag_t;

  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic             sat;
  } res_t;

endpackage

// ===== hw/rtl/fps_regs.sv =====
module fps_regs
  import fps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  cfg_t cfg_r;
  logic wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.row_width       <= ROW_WIDTH_RST;
      cfg_r.center_weight   <= CENTER_WEIGHT_RST;
      cfg_r.neighbor_weight <= NEIGHBOR_WEIGHT_RST;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_ROW_WIDTH:       cfg_r.row_width       <= pwdata[RW_W-1:0];
        REG_CENTER_WEIGHT:   cfg_r.center_weight   <= pwdata[WT_W-1:0];
        REG_NEIGHBOR_WEIGHT: cfg_r.neighbor_weight <= pwdata[WT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_ROW_WIDTH:       prdata = {{(32-RW_W){1'b0}}, cfg_r.row_width};
      REG_CENTER_WEIGHT:   prdata = {{(32-WT_W){1'b0}}, cfg_r.center_weight};
      REG_NEIGHBOR_WEIGHT: prdata = {{(32-WT_W){1'b0}}, cfg_r.neighbor_weight};
      default:             prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/fps_line_buf.sv =====
module fps_line_buf
  import fps_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr_nx,
  input  logic                         wr_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
  input  logic [ENT_W-1:0]             wr_prev,
  input  logic [ENT_W-1:0]             wr_old,
  output win_t                         win
);

  localparam int CW = $clog2(MAX_WIDTH + 1);

  logic [ENT_W-1:0] mem_prev_r [MAX_WIDTH];
  logic [ENT_W-1:0] mem_old_r  [MAX_WIDTH];

  // Rows are always written from column zero upward, so every entry below
  // the fill mark has been written and every entry above still reads zero.
  logic [CW-1:0]    fill_r, fill_nxt;

  logic [ENT_W-1:0] rd_held_r, rd_up_r, rd_right_r;
  logic [ENT_W-1:0] byp_prev_r, byp_old_r;
  logic             hit_c_r, hit_nx_r, vld_c_r, vld_nx_r;

  always_comb begin
    fill_nxt = fill_r;
    if (wr_en && (32'(wr_addr) >= 32'(fill_r))) begin
      fill_nxt = CW'(32'(wr_addr) + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_prev_r[wr_addr] <= wr_prev;
      mem_old_r[wr_addr]  <= wr_old;
    end
    if (rd_en) begin
      rd_held_r  <= mem_prev_r[rd_addr];
      rd_right_r <= mem_prev_r[rd_addr_nx];
      rd_up_r    <= mem_old_r[rd_addr];
    end
  end

  // A write landing on the same edge as a read is forwarded.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      hit_c_r    <= wr_en && (wr_addr == rd_addr);
      hit_nx_r   <= wr_en && (wr_addr == rd_addr_nx);
      vld_c_r    <= 32'(rd_addr) < 32'(fill_r);
      vld_nx_r   <= 32'(rd_addr_nx) < 32'(fill_r);
      byp_prev_r <= wr_prev;
      byp_old_r  <= wr_old;
    end
  end

  always_comb begin
    win.held  = hit_c_r  ? byp_prev_r : (vld_c_r  ? rd_held_r  : '0);
    win.up    = hit_c_r  ? byp_old_r  : (vld_c_r  ? rd_up_r    : '0);
    win.right = hit_nx_r ? byp_prev_r : (vld_nx_r ? rd_right_r : '0);
  end

`ifndef SYNTHESIS
  a_write_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (32'(wr_addr) <= 32'(fill_r)))
    else $error("line buffer write skips past the fill mark");

  a_fill_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (fill_r >= $past(fill_r)))
    else $error("line buffer fill mark moved backward");
`endif

endmodule

// ===== hw/rtl/fps_calc.sv =====
module fps_calc
  import fps_pkg::*;
(
  input  logic [WT_W-1:0]  center_weight,
  input  logic [WT_W-1:0]  neighbor_weight,
  input  logic [PIX_W-1:0] center,
  input  logic [PIX_W-1:0] up,
  input  logic [PIX_W-1:0] down,
  input  logic [PIX_W-1:0] left,
  input  logic [PIX_W-1:0] right,
  output res_t             res
);

  logic [17:0] sum4;
  logic [31:0] prod_c;
  logic [33:0] prod_n;
  logic [34:0] acc, rnd;
  logic [18:0] q;

  always_comb begin
    sum4   = 18'(up) + 18'(down) + 18'(left) + 18'(right);
    prod_c = 32'(center_weight) * 32'(center);
    prod_n = 34'(neighbor_weight) * 34'(sum4);
    // Q11.24 sum, rounded half up to Q8.8.
    acc    = 35'(prod_c) + 35'(prod_n);
    rnd    = acc + 35'h8000;
    q      = rnd[34:16];
    res.sat   = |q[18:16];
    res.value = res.sat ? {PIX_W{1'b1}} : q[15:0];
  end

endmodule

// ===== hw/rtl/five_point_stencil_filter_top.sv =====
// Five-point stencil filter for a row-major tile of unsigned Q8.8 pixels. Each tile pixel
// becomes center_weight * center + neighbor_weight * (up + down + left + right), with Q0.16
// weights, rounded to nearest and saturated to 16 bits (out_saturated flags clipping).
// Pixels beyond the row ends and the row above the first row of a frame count as zero.
// A pixel's result leaves when the pixel below it arrives, one row later, so the host ends
// every frame with one halo row (in_func = 1), which feeds neighbours but makes no output;
// out_last follows the request that carried in_end_of_frame. The block takes one request
// per clock while results drain and has two register stages: an input stage holding the
// pixel and the line buffer reads, and the result register. For each request the line
// buffers read the previous row at two columns and the row before it at one column. No
// clearing pass is needed after reset: a fill mark tracks the written part of the buffers.
// Registers (APB, byte address 4 * index): 0 row_width (1..MAX_WIDTH, zero acts as one,
// larger values as MAX_WIDTH), 1 center_weight, 2 neighbor_weight. Write them only while
// the block is idle.
module five_point_stencil_filter_top
  import fps_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_func,
  input  logic [PIX_W-1:0]  in_pixel_value,
  input  logic              in_end_of_frame,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [PIX_W-1:0]  out_result_value,
  output logic              out_saturated,
  output logic              out_last,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH + 1);

  cfg_t cfg;

  fps_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Active row width, clamped to the buffer depth.
  logic [CW-1:0] w_eff;

  always_comb begin
    if (cfg.row_width == '0) begin
      w_eff = CW'(1);
    end else if (32'(cfg.row_width) > MAX_WIDTH) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(cfg.row_width);
    end
  end

  // Column and row position of the next request.
  logic [AW-1:0] col_r, col_nxt;
  logic [1:0]    rows_r, rows_nxt;

  logic          accept;
  logic          wrap, end_row;
  logic [AW-1:0] col_cur, rd_addr_nx;
  logic [AW:0]   col_p1;
  logic [1:0]    rows_cur;
  flag_t         flags;

  assign accept = in_valid && in_ready;

  always_comb begin
    // If the width was narrowed below the current column, that row ends here.
    wrap     = 32'(col_r) >= 32'(w_eff);
    col_cur  = wrap ? '0 : col_r;
    rows_cur = (wrap && rows_r != 2'd3) ? rows_r + 2'd1 : rows_r;
    col_p1   = {1'b0, col_cur} + {{AW{1'b0}}, 1'b1};
    end_row  = 32'(col_p1) >= 32'(w_eff);

    flags.left_en  = col_cur != '0;
    flags.right_en = !end_row;
    flags.up_en    = rows_cur >= 2'd2;
    flags.rows_ok  = rows_cur != 2'd0;

    rd_addr_nx = end_row ? col_cur : col_p1[AW-1:0];

    if (in_end_of_frame) begin
      col_nxt  = '0;
      rows_nxt = '0;
    end else if (end_row) begin
      col_nxt  = '0;
      rows_nxt = (rows_cur != 2'd3) ? rows_cur + 2'd1 : rows_cur;
    end else begin
      col_nxt  = col_p1[AW-1:0];
      rows_nxt = rows_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      rows_r <= '0;
    end else if (accept) begin
      col_r  <= col_nxt;
      rows_r <= rows_nxt;
    end
  end

  // Input stage: the request waits here while the line buffer data arrives.
  logic             s1_valid_r;
  logic             s1_fire;
  logic [PIX_W-1:0] s1_px_r;
  logic             s1_tile_r;
  logic             s1_eof_r;
  logic [AW-1:0]    s1_addr_r;
  flag_t            s1_flags_r;
  logic [ENT_W-1:0] last_held_r;
  win_t             win;
  logic             emit;

  logic             out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0] out_value_r;
  logic             out_sat_r;
  logic             out_last_r;

  assign s1_fire  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;
  assign emit     = s1_flags_r.rows_ok && win.held[PIX_W];

  fps_line_buf #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_en      (accept),
    .rd_addr    (col_cur),
    .rd_addr_nx (rd_addr_nx),
    .wr_en      (s1_fire),
    .wr_addr    (s1_addr_r),
    .wr_prev    ({s1_tile_r, s1_px_r}),
    .wr_old     (win.held),
    .win        (win)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px_r    <= in_pixel_value;
      s1_tile_r  <= !in_func;
      s1_eof_r   <= in_end_of_frame;
      s1_addr_r  <= col_cur;
      s1_flags_r <= flags;
    end
    // The left neighbour is the center of the request before, in the same row.
    if (s1_fire) begin
      last_held_r <= win.held;
    end
  end

  res_t res;

  fps_calc u_calc (
    .center_weight   (cfg.center_weight),
    .neighbor_weight (cfg.neighbor_weight),
    .center          (win.held[PIX_W-1:0]),
    .up              (s1_flags_r.up_en    ? win.up[PIX_W-1:0]      : '0),
    .down            (s1_px_r),
    .left            (s1_flags_r.left_en  ? last_held_r[PIX_W-1:0] : '0),
    .right           (s1_flags_r.right_en ? win.right[PIX_W-1:0]   : '0),
    .res             (res)
  );

  // Result register.
  assign out_valid_nxt = s1_fire ? emit : (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && emit) begin
      out_value_r <= res.value;
      out_sat_r   <= res.sat;
      out_last_r  <= s1_eof_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_saturated    = out_sat_r;
  assign out_last         = out_last_r;

`ifndef SYNTHESIS
  a_eof_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_end_of_frame) |=> (col_r == '0 && rows_r == '0))
    else $error("position not cleared after end of frame");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_fire) |=> (s1_valid_r && $stable(s1_addr_r)))
    else $error("stalled input stage lost its request");

  a_no_output_for_halo: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && !emit) |=> !out_valid_r)
    else $error("result produced for a request without a tile center");
`endif

endmodule

// ===== bench/five_point_stencil_filter_top_tb.sv =====
module five_point_stencil_filter_top_tb;
  import fps_pkg::*;

  // Kinds of pixel carried by in_func.
  localparam logic FUNC_TILE = 1'b0;
  localparam logic FUNC_HALO = 1'b1;

  // An address past the last register; writes there must change nothing.
  localparam logic [1:0] REG_SPARE = 2'd3;

  localparam int CLK_PERIOD      = 8;
  localparam int SETTLE_CYCLES   = 6;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int PHASE_PIXELS    = 48;
  localparam int WIDE_PIXELS     = 8;
  localparam int TIMEOUT_CYCLES  = 400000;

  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic             sat;
    logic             last;
  } filtered_pixel_t;

  // Mirrors the line buffers and registers of the filter and holds the filtered
  // pixels that the block still owes, oldest first.
  class stencil_checker;
    logic [RW_W-1:0]  row_width;
    logic [WT_W-1:0]  center_weight;
    logic [WT_W-1:0]  neighbor_weight;
    logic [ENT_W-1:0] previous_line [MAX_WIDTH_DEF];
    logic [ENT_W-1:0] older_line [MAX_WIDTH_DEF];
    int unsigned      column;
    int unsigned      rows_done;
    filtered_pixel_t  owed_pixels [$];
    int unsigned      failures;

    function new();
      row_width = ROW_WIDTH_RST;
      center_weight = CENTER_WEIGHT_RST;
      neighbor_weight = NEIGHBOR_WEIGHT_RST;
      foreach (previous_line[i]) begin
        previous_line[i] = '0;
        older_line[i] = '0;
      end
      column = 0;
      rows_done = 0;
      failures = 0;
    endfunction

    function void set_register(logic [1:0] index, logic [31:0] data);
      case (index)
        REG_ROW_WIDTH:       row_width = data[RW_W-1:0];
        REG_CENTER_WEIGHT:   center_weight = data[WT_W-1:0];
        REG_NEIGHBOR_WEIGHT: neighbor_weight = data[WT_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned active_width();
      if (row_width == 0) return 1;
      if (row_width > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
      return row_width;
    endfunction

    function void close_row();
      column = 0;
      if (rows_done < 3) rows_done++;
    endfunction

    // The pixel that arrives is the lower neighbor of the stored pixel in the
    // same column, which is filtered now if it was a tile pixel.
    function void note_request(logic func, logic [PIX_W-1:0] pixel, logic eof);
      int unsigned     w;
      int unsigned     c;
      logic [ENT_W-1:0] held;
      logic [63:0]     up;
      logic [63:0]     left;
      logic [63:0]     right;
      logic [63:0]     acc;
      logic [63:0]     rounded;
      filtered_pixel_t r;
      w = active_width();
      if (column >= w) close_row();
      c = column;
      held = previous_line[c];
      if (rows_done >= 1 && held[PIX_W]) begin
        up = (rows_done >= 2) ? 64'(older_line[c][PIX_W-1:0]) : 64'd0;
        left = (c > 0) ? 64'(older_line[c-1][PIX_W-1:0]) : 64'd0;
        right = (c + 1 < w) ? 64'(previous_line[c+1][PIX_W-1:0]) : 64'd0;
        acc = 64'(center_weight) * 64'(held[PIX_W-1:0])
            + 64'(neighbor_weight) * (up + 64'(pixel) + left + right);
        rounded = (acc + 64'h8000) >> 16;
        r.sat = (rounded > 64'hFFFF);
        r.value = r.sat ? {PIX_W{1'b1}} : rounded[PIX_W-1:0];
        r.last = eof;
        owed_pixels.push_back(r);
      end
      older_line[c] = held;
      previous_line[c] = {func == FUNC_TILE, pixel};
      column++;
      if (eof) begin
        column = 0;
        rows_done = 0;
      end else if (column >= w) begin
        close_row();
      end
    endfunction

    function void complain(string what);
      failures++;
      if (failures <= 10) $display("[%0t] %s", $realtime, what);
    endfunction

    function void check_result(logic [PIX_W-1:0] value, logic sat, logic last);
      filtered_pixel_t want;
      if (owed_pixels.size() == 0) begin
        complain($sformatf("unexpected result value=%h sat=%b last=%b", value, sat, last));
        return;
      end
      want = owed_pixels.pop_front();
      if (value !== want.value || sat !== want.sat || last !== want.last)
        complain($sformatf("mismatch: want value=%h sat=%b last=%b got value=%h sat=%b last=%b",
                           want.value, want.sat, want.last, value, sat, last));
    endfunction
  endclass

  // All block inputs start at known values; the stimulus tasks move them
  // with nonblocking assignments at rising edges only.
  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic             in_func = FUNC_TILE;
  logic [PIX_W-1:0] in_pixel_value = '0;
  logic             in_end_of_frame = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [PIX_W-1:0] out_result_value;
  logic             out_saturated;
  logic             out_last;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [3:0]       paddr = '0;
  logic [31:0]      pwdata = '0;
  logic [31:0]      prdata;
  logic             pready;

  stencil_checker   ledger;

  // Handshake seen at the last falling edge, which is the one the next rising
  // edge will complete.
  logic             in_take = 1'b0;

  // Idling knobs for the current phase, in percent of cycles.
  int unsigned      send_gap_pct = 0;
  int unsigned      stall_pct = 0;
  logic             hold_request = 1'b0;
  int unsigned      pixels_sent = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  five_point_stencil_filter_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_pixel_value   (in_pixel_value),
    .in_end_of_frame  (in_end_of_frame),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_value (out_result_value),
    .out_saturated    (out_saturated),
    .out_last         (out_last),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // Both channels are observed at the falling edge, after the rising edge at which the
  // inputs moved and before the edge that completes a request. Sampling there keeps the
  // checks free of races with the block's own register updates. A request is noted before
  // its results can appear, since the block registers every result before it shows it.
  always @(negedge clk) begin
    in_take = rst_n && in_valid && in_ready;
    if (in_take) ledger.note_request(in_func, in_pixel_value, in_end_of_frame);
    if (rst_n && out_valid && out_ready)
      ledger.check_result(out_result_value, out_saturated, out_last);
  end

  // Result side. Normally out_ready is random per cycle at the phase's stall
  // rate. On request it holds off for a long stretch, so that the two
  // pipeline stages fill and the block has to drop in_ready.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Offers one pixel request, after a random gap at the phase's idle rate,
  // and returns at the edge that accepts it. in_valid stays high afterwards
  // so that back-to-back requests never drop it in between.
  task automatic send_pixel(logic func, logic [PIX_W-1:0] pixel, logic eof);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= func;
    in_pixel_value <= pixel;
    in_end_of_frame <= eof;
    @(posedge clk);
    while (!in_take) @(posedge clk);
    pixels_sent++;
  endtask

  // Edge values show up often enough to hit saturation and all-zero sums.
  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(7))
      0: return '0;
      1: return {PIX_W{1'b1}};
      default: return PIX_W'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_weight();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return 32'hFFFF;
      2: return 32'(CENTER_WEIGHT_RST);
      default: return 32'($urandom_range(65535));
    endcase
  endfunction

  task automatic send_row(logic func, int unsigned count, logic eof_at_end);
    for (int unsigned k = 1; k <= count; k++)
      send_pixel(func, pick_pixel(), eof_at_end && k == count);
  endtask

  // Most frames are well formed: an optional halo row on top, one to four
  // tile rows and the closing halo row carrying end of frame. The rest is
  // noise: pixels of random kind with end of frame at an arbitrary column,
  // which also drops partial rows.
  task automatic send_frame();
    int unsigned cols;
    int unsigned count;
    cols = ledger.active_width();
    if ($urandom_range(99) < 80) begin
      if ($urandom_range(1) == 1) send_row(FUNC_HALO, cols, 1'b0);
      repeat ($urandom_range(1, 4)) send_row(FUNC_TILE, cols, 1'b0);
      send_row(FUNC_HALO, cols, 1'b1);
    end else begin
      count = $urandom_range(1, 3 * cols + 2);
      for (int unsigned k = 1; k <= count; k++)
        send_pixel(1'($urandom_range(1)), pick_pixel(), k == count);
    end
  endtask

  // Drops in_valid and waits until every owed pixel has come out, then lets the pipeline
  // drain, since a halo pixel may still be in it with no result to show for it.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (ledger.owed_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: a setup phase and an access phase, done at the edge with pready high.
  // psel and penable then stay low until the task returns, so that back-to-back
  // writes never assign psel twice in one time step.
  task automatic write_register(logic [1:0] index, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    ledger.set_register(index, data);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    ledger = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, at the reset weights first. A row of width four is cut
    // short by narrowing the width to two, so the next pixel starts a new
    // row. The width then grows back to three between rows, which makes the
    // stale third entry of the cut row a center. The frame ends on a halo
    // row that stops part way, so that partial row is dropped.
    write_register(REG_ROW_WIDTH, 32'd4);
    send_pixel(FUNC_TILE, 16'h0100, 1'b0);
    send_pixel(FUNC_TILE, 16'h0200, 1'b0);
    send_pixel(FUNC_TILE, 16'h0300, 1'b0);
    settle();
    write_register(REG_ROW_WIDTH, 32'd2);
    send_pixel(FUNC_TILE, 16'h0400, 1'b0);
    send_pixel(FUNC_TILE, 16'hFFFF, 1'b0);
    settle();
    write_register(REG_ROW_WIDTH, 32'd3);
    send_pixel(FUNC_TILE, 16'h0000, 1'b0);
    send_pixel(FUNC_TILE, 16'h1234, 1'b0);
    send_pixel(FUNC_TILE, 16'h8000, 1'b0);
    send_pixel(FUNC_HALO, 16'h0000, 1'b0);
    send_pixel(FUNC_HALO, 16'h00FF, 1'b1);
    settle();

    // Full-scale weights on full-scale pixels: every result clips.
    write_register(REG_ROW_WIDTH, 32'd2);
    write_register(REG_CENTER_WEIGHT, 32'hFFFF);
    write_register(REG_NEIGHBOR_WEIGHT, 32'hFFFF);
    repeat (2) send_pixel(FUNC_TILE, 16'hFFFF, 1'b0);
    repeat (2) send_pixel(FUNC_TILE, 16'hFFFF, 1'b0);
    send_pixel(FUNC_HALO, 16'hFFFF, 1'b0);
    send_pixel(FUNC_HALO, 16'hFFFF, 1'b1);
    settle();

    // A write past the register list must not disturb anything. A halo row
    // on top gives no results of its own, and a half-weight center on odd
    // values lands exactly on the rounding midpoint, which rounds up.
    write_register(REG_SPARE, 32'hFFFF_FFFF);
    write_register(REG_CENTER_WEIGHT, 32'h8000);
    write_register(REG_NEIGHBOR_WEIGHT, 32'd0);
    send_pixel(FUNC_HALO, 16'h0100, 1'b0);
    send_pixel(FUNC_HALO, 16'h0200, 1'b0);
    send_pixel(FUNC_TILE, 16'h0001, 1'b0);
    send_pixel(FUNC_TILE, 16'h0003, 1'b0);
    send_pixel(FUNC_HALO, 16'h0000, 1'b0);
    send_pixel(FUNC_HALO, 16'h0000, 1'b1);

    // Random phases. The idling pattern rotates through none, sender gaps,
    // receiver stalls and a little of both. Widths of zero and one come
    // first, then small random widths keep rows short and results frequent.
    for (int unsigned phase = 0; phase < 8; phase++) begin
      int unsigned start;
      settle();
      case (phase % 4)
        0: begin
          send_gap_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_gap_pct = 58;
          stall_pct = 0;
        end
        2: begin
          send_gap_pct = 0;
          stall_pct = 58;
        end
        default: begin
          send_gap_pct = 8;
          stall_pct = 8;
        end
      endcase
      case (phase)
        0: write_register(REG_ROW_WIDTH, 32'd0);
        1: write_register(REG_ROW_WIDTH, 32'd1);
        default: write_register(REG_ROW_WIDTH, 32'($urandom_range(2, 9)));
      endcase
      write_register(REG_CENTER_WEIGHT, pick_weight());
      write_register(REG_NEIGHBOR_WEIGHT, pick_weight());
      // The receiver holds off while the sender keeps streaming with no gaps.
      if (phase == 4) hold_request = 1'b1;
      start = pixels_sent;
      while (pixels_sent - start < PHASE_PIXELS) send_frame();
    end

    // The register's top value is taken as the full line buffer depth, so a
    // short frame at that width never completes a row and gives no results.
    settle();
    send_gap_pct = 8;
    stall_pct = 8;
    write_register(REG_ROW_WIDTH, 32'h7FF);
    write_register(REG_CENTER_WEIGHT, 32'(CENTER_WEIGHT_RST));
    write_register(REG_NEIGHBOR_WEIGHT, 32'(NEIGHBOR_WEIGHT_RST));
    send_row(FUNC_TILE, WIDE_PIXELS, 1'b0);
    send_row(FUNC_HALO, WIDE_PIXELS, 1'b1);

    settle();
    if (ledger.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Safety net for a hung handshake or results that never arrive.
  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/fps_pkg.sv
hw/rtl/fps_regs.sv
hw/rtl/fps_line_buf.sv
hw/rtl/fps_calc.sv
hw/rtl/five_point_stencil_filter_top.sv
bench/five_point_stencil_filter_top_tb.sv
